FILE: src/perceptron_train_predict_assert.svh
// Assertion macros for the perceptron block.
// Uses the clk and arst_n of the module that includes it.
`ifndef PERCEPTRON_TRAIN_PREDICT_ASSERT_SVH
`define PERCEPTRON_TRAIN_PREDICT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PCTP_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define PCTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define PCTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PCTP_ASSERT_ALWAYS(lbl, expr, msg)
`define PCTP_ASSERT_IMP(lbl, ante, cons, msg)
`define PCTP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/pctp_pkg.sv
// Shared types, constants and helpers for the perceptron block.
// No dependencies.
package pctp_pkg;

	localparam int NUM_CLASSES_DEF = 2;

	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 16;
	localparam int Q_W      = 32;                    // Q15.16 weight and bias
	localparam int PROD_W   = Q_W + SAMPLE_W;        // weight * sample, Q.24
	localparam int SCORE_W  = PROD_W + 1;            // plus bias * 256
	localparam int WMAG_W   = RATE_W + SAMPLE_W - 7; // rounded step magnitude
	localparam int BSTEP_W  = RATE_W - 1;

	localparam logic [RATE_W-1:0] RATE_RESET = 16'd3277;

	// APB map: one register, word aligned
	localparam int  PADDR_W       = 3;
	localparam int  PDATA_W       = 32;
	localparam logic CFG_IDX_RATE = 1'b0;

	typedef struct packed {
		logic                        req_type;
		logic signed [SAMPLE_W-1:0]  sensor_value;
		logic                        label;
	} req_t;

	typedef struct packed {
		logic chosen_class;
		logic updated;
	} rsp_t;

	// what travels down the row of cells with one sample
	typedef struct packed {
		logic                        train;
		logic                        label;
		logic signed [SAMPLE_W-1:0]  sample;
		logic [WMAG_W-1:0]           wmag;
		logic [BSTEP_W-1:0]          bstep;
		logic                        best_v;
		logic signed [SCORE_W-1:0]   best;
		logic                        best_lsb;
		logic                        changed;
	} tok_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W:0] v);
		logic signed [Q_W-1:0] r;
		if (v[Q_W] != v[Q_W-1]) begin
			r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: src/pctp_apb.sv
// APB register file: holds the step rate.
// Depends on pctp_pkg.
module pctp_apb
	import pctp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [RATE_W-1:0]  step_rate
);

	logic [RATE_W-1:0] rate_q;
	logic              hit_rate;

	assign hit_rate  = (paddr[PADDR_W-1] == CFG_IDX_RATE);
	assign pready    = 1'b1;
	assign step_rate = rate_q;
	assign prdata    = hit_rate ? {{(PDATA_W-RATE_W){1'b0}}, rate_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (psel && penable && pwrite && hit_rate) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

endmodule

FILE: src/pctp_cell.sv
// One class of the perceptron: weight, bias, score, argmax step and update.
// Depends on pctp_pkg.
module pctp_cell
	import pctp_pkg::*;
#(
	parameter int IDX = 0
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  tok_t in_tok,
	output logic out_valid,
	output tok_t out_tok
);

	localparam logic IDX_IS0 = (IDX == 0);
	localparam logic IDX_IS1 = (IDX == 1);
	localparam logic IDX_LSB = 1'(IDX % 2);

	logic signed [Q_W-1:0]    weight_q;
	logic signed [Q_W-1:0]    bias_q;

	logic                     v_s1;
	tok_t                     tok_s1;
	logic signed [PROD_W-1:0] prod_s1;

	logic                     v_s2;
	tok_t                     tok_s2;

	logic signed [SCORE_W-1:0] score;
	logic                      better;
	logic                      pred;
	logic                      target;
	logic                      err_up;
	logic                      err_dn;
	logic                      do_upd;
	logic                      w_inc;
	logic signed [Q_W:0]       w_sum;
	logic signed [Q_W:0]       b_sum;
	logic signed [Q_W-1:0]     w_new;
	logic signed [Q_W-1:0]     b_new;
	logic                      chg;
	tok_t                      tok_nxt;

	always_comb begin
		score  = $signed({{(SCORE_W-Q_W-8){bias_q[Q_W-1]}}, bias_q, 8'b0})
			+ $signed({prod_s1[PROD_W-1], prod_s1});
		better = !tok_s1.best_v || (score > tok_s1.best);
		pred   = !score[SCORE_W-1] && (|score);
		target = tok_s1.label ? IDX_IS1 : IDX_IS0;
		err_up = target && !pred;
		err_dn = !target && pred;
		do_upd = tok_s1.train && (err_up || err_dn);
		// step sign is error sign times sample sign
		w_inc  = err_up ^ tok_s1.sample[SAMPLE_W-1];
		if (w_inc) begin
			w_sum = {weight_q[Q_W-1], weight_q}
				+ $signed({{(Q_W+1-WMAG_W){1'b0}}, tok_s1.wmag});
		end else begin
			w_sum = {weight_q[Q_W-1], weight_q}
				- $signed({{(Q_W+1-WMAG_W){1'b0}}, tok_s1.wmag});
		end
		if (err_up) begin
			b_sum = {bias_q[Q_W-1], bias_q}
				+ $signed({{(Q_W+1-BSTEP_W){1'b0}}, tok_s1.bstep});
		end else begin
			b_sum = {bias_q[Q_W-1], bias_q}
				- $signed({{(Q_W+1-BSTEP_W){1'b0}}, tok_s1.bstep});
		end
		w_new = sat_q(w_sum);
		b_new = sat_q(b_sum);
		chg   = do_upd && ((w_new != weight_q) || (b_new != bias_q));

		tok_nxt         = tok_s1;
		tok_nxt.best_v  = 1'b1;
		tok_nxt.changed = tok_s1.changed || chg;
		if (better) begin
			tok_nxt.best     = score;
			tok_nxt.best_lsb = IDX_LSB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			weight_q <= '0;
			bias_q   <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			if (v_s1 && do_upd) begin
				weight_q <= w_new;
				bias_q   <= b_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_s1  <= in_tok;
		prod_s1 <= weight_q * in_tok.sample;
		tok_s2  <= tok_nxt;
	end

	assign out_valid = v_s2;
	assign out_tok   = tok_s2;

endmodule

FILE: src/perceptron_train_predict.sv
// Top level of the online multiclass perceptron: APB register, entry stage,
// row of class cells, result register. Depends on pctp_pkg, pctp_apb, pctp_cell.
//
//   channel  payload  handshake              direction
//   req      req_t    req_valid / req_stall  in
//   rsp      rsp_t    rsp_valid / rsp_stall  out
//   apb      rate     psel/penable/pwrite    in (pready always high)
//
// One sample at a time: a transfer in passes the entry register, two stages per class
// (multiply, then score/update), the hold register and the rsp register, where
// rsp_valid rises. The next sample can transfer in the cycle in which rsp_valid rises.
// req_stall is high from a transfer in until its result reaches the rsp register;
// a new sample is taken while that result waits on rsp_stall.
// Reset clears weights and biases to zero and loads the rate with 3277.
module perceptron_train_predict
	import pctp_pkg::*;
#(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp
);

	logic [RATE_W-1:0]   step_rate;
	logic                accept;
	logic                busy_q;
	logic [SAMPLE_W-1:0] mag;
	logic [RATE_W+SAMPLE_W-1:0] rate_mag;
	logic [RATE_W+SAMPLE_W:0]   rate_rnd;

	logic                entry_v_s1;
	tok_t                entry_s1;

	logic [NUM_CLASSES:0] tok_v;
	tok_t                 tok [NUM_CLASSES+1];

	logic                fin_v_q;
	tok_t                fin_q;
	logic                move;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	pctp_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.step_rate(step_rate)
	);

	assign accept    = req_valid && !req_stall;
	assign req_stall = busy_q;

	// weight step magnitude, rounded half away from zero
	always_comb begin
		mag      = req.sensor_value[SAMPLE_W-1] ? (~req.sensor_value + 16'd1)
			: req.sensor_value;
		rate_mag = step_rate * mag;
		rate_rnd = {1'b0, rate_mag} + (RATE_W+SAMPLE_W+1)'(128);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_v_s1 <= 1'b0;
		end else begin
			entry_v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.train    <= req.req_type;
			entry_s1.label    <= req.label;
			entry_s1.sample   <= req.sensor_value;
			entry_s1.wmag     <= rate_rnd[RATE_W+SAMPLE_W:8];
			entry_s1.bstep    <= step_rate[RATE_W-1:1];
			entry_s1.best_v   <= 1'b0;
			entry_s1.best     <= '0;
			entry_s1.best_lsb <= 1'b0;
			entry_s1.changed  <= 1'b0;
		end
	end

	assign tok_v[0] = entry_v_s1;
	assign tok[0]   = entry_s1;

	for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cell
		pctp_cell #(.IDX(c)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (tok_v[c]),
			.in_tok   (tok[c]),
			.out_valid(tok_v[c+1]),
			.out_tok  (tok[c+1])
		);
	end

	assign move = fin_v_q && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fin_v_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (tok_v[NUM_CLASSES]) begin
				fin_v_q <= 1'b1;
			end else if (move) begin
				fin_v_q <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_v[NUM_CLASSES]) begin
			fin_q <= tok[NUM_CLASSES];
		end
		if (move) begin
			rsp_q.chosen_class <= fin_q.best_lsb;
			rsp_q.updated      <= fin_q.changed;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "perceptron_train_predict_assert.svh"

	`PCTP_ASSERT_ALWAYS(a_one_sample, $onehot0({fin_v_q, tok_v}), "two samples in flight")
	`PCTP_ASSERT_NEXT(a_enter_row, accept, tok_v[0], "accepted sample did not enter the row")
	`PCTP_ASSERT_IMP(a_idle_empty, !busy_q, !fin_v_q && (tok_v == '0), "work left while idle")
	`PCTP_ASSERT_IMP(a_pred_no_chg, fin_v_q && !fin_q.train, !fin_q.changed, "predict updated")
	`PCTP_ASSERT_IMP(a_zero_rate, fin_v_q && (step_rate == '0), !fin_q.changed, "zero rate")

endmodule
